// File: sv/lphm_pkg.sv
// ----------------------------------------------------------------------
// lphm_pkg : shared types and constants of the linear-probe hash map
// Request classes, status codes, queue entry layout and the byte mask
// helper used by the front end.
// ----------------------------------------------------------------------
package lphm_pkg;

  localparam int unsigned TABLE_SLOTS_DEF = 256;
  localparam int unsigned VALUE_BYTES_DEF = 8;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned LEN_W   = 4;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned LIMIT_W = 8;

  localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RST = 8'd192;

  localparam logic [FUNC_W-1:0] FUNC_SET    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD_KEY   = 2'd3;

  typedef enum logic [1:0] {
    OP_SET,
    OP_LOOKUP,
    OP_REMOVE,
    OP_BADKEY
  } op_t;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_PROBE
  } back_state_t;

  typedef struct packed {
    op_t                op;
    logic [KEY_W-1:0]   key;
    logic [DATA_W-1:0]  value;
    logic [LEN_W-1:0]   len;
  } req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

  function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int b = 0; b < DATA_W / 8; b++) begin
      m[b*8 +: 8] = (LEN_W'(b) < len) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

// File: sv/lphm_front.sv
// ----------------------------------------------------------------------
// lphm_front : request intake and classification
// Takes request beats, sorts them into set / lookup / remove / bad key,
// saturates the value length, masks unused value bytes and pushes the
// result into the request queue.
// ----------------------------------------------------------------------
module lphm_front #(
  parameter int unsigned VALUE_BYTES = lphm_pkg::VALUE_BYTES_DEF
) (
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [lphm_pkg::FUNC_W-1:0]     in_func,
  input  logic [lphm_pkg::KEY_W-1:0]      in_key_hash,
  input  logic [lphm_pkg::DATA_W-1:0]     in_value_data,
  input  logic [lphm_pkg::LEN_W-1:0]      in_value_len,
  input  lphm_pkg::q_stat_t               q_stat,
  input  lphm_pkg::back_stat_t            back_stat,
  output logic                            q_push,
  output lphm_pkg::req_t                  q_entry
);

  logic [lphm_pkg::LEN_W-1:0] len_sat;

  assign in_stall = q_stat.full | back_stat.clearing;
  assign q_push   = in_valid & ~in_stall;

  always_comb begin
    len_sat = (in_value_len > lphm_pkg::LEN_W'(VALUE_BYTES)) ?
              lphm_pkg::LEN_W'(VALUE_BYTES) : in_value_len;

    q_entry.key   = in_key_hash;
    q_entry.len   = len_sat;
    q_entry.value = in_value_data & lphm_pkg::byte_mask(len_sat);

    if (in_key_hash == '0) begin
      q_entry.op = lphm_pkg::OP_BADKEY;
    end else begin
      case (in_func)
        lphm_pkg::FUNC_SET:    q_entry.op = lphm_pkg::OP_SET;
        lphm_pkg::FUNC_REMOVE: q_entry.op = lphm_pkg::OP_REMOVE;
        // unused code behaves as a lookup
        default:               q_entry.op = lphm_pkg::OP_LOOKUP;
      endcase
    end
  end

endmodule

// File: sv/lphm_queue.sv
// ----------------------------------------------------------------------
// lphm_queue : request queue between front end and probe engine
// Small circular buffer of classified requests; lets the front end keep
// taking beats while the probe engine works or waits on the output.
// ----------------------------------------------------------------------
module lphm_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  lphm_pkg::req_t       push_entry,
  input  logic                 pop,
  output lphm_pkg::req_t       head,
  output lphm_pkg::q_stat_t    q_stat
);

  localparam int unsigned DEPTH = lphm_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  lphm_pkg::req_t     q_mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  assign head         = q_mem_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign q_stat.empty = (cnt_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// File: sv/lphm_back.sv
// ----------------------------------------------------------------------
// lphm_back : probe engine and slot table
// Clears the slot table after reset, then takes requests from the queue,
// walks the probe chain one slot per cycle, applies the set or remove and
// holds the response in the output register.
// ----------------------------------------------------------------------
module lphm_back #(
  parameter int unsigned TABLE_SLOTS = lphm_pkg::TABLE_SLOTS_DEF,
  parameter int unsigned VALUE_BYTES = lphm_pkg::VALUE_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [lphm_pkg::LIMIT_W-1:0]    load_limit,
  input  lphm_pkg::req_t                  q_head,
  input  lphm_pkg::q_stat_t               q_stat,
  output logic                            q_pop,
  output lphm_pkg::back_stat_t            back_stat,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [lphm_pkg::STAT_W-1:0]     out_status,
  output logic                            out_new_key,
  output logic [lphm_pkg::DATA_W-1:0]     out_value_out,
  output logic [lphm_pkg::LEN_W-1:0]      out_value_out_len,
  output logic [lphm_pkg::COUNT_W-1:0]    out_entry_count
);

  localparam int unsigned IDX_W = $clog2(TABLE_SLOTS);
  localparam int unsigned VW    = 8 * VALUE_BYTES;
  localparam int unsigned KW    = lphm_pkg::KEY_W;
  localparam int unsigned LW    = lphm_pkg::LEN_W;
  localparam int unsigned CW    = lphm_pkg::COUNT_W;

  // slot table
  logic [KW-1:0] key_mem [TABLE_SLOTS];
  logic [VW-1:0] val_mem [TABLE_SLOTS];
  logic [LW-1:0] len_mem [TABLE_SLOTS];

  logic [KW-1:0]    rd_key_r;
  logic [VW-1:0]    rd_val_r;
  logic [LW-1:0]    rd_len_r;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic [KW-1:0]    mem_wkey;
  logic [VW-1:0]    mem_wval;
  logic [LW-1:0]    mem_wlen;

  lphm_pkg::back_state_t state_r, state_nxt;
  lphm_pkg::req_t        op_r;
  logic [IDX_W-1:0]      clr_r, clr_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [IDX_W-1:0]      n_r, n_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic                    res_load;
  logic [lphm_pkg::STAT_W-1:0] res_status;
  logic                    res_new;
  logic [lphm_pkg::DATA_W-1:0] res_val;
  logic [LW-1:0]           res_len;
  logic [lphm_pkg::STAT_W-1:0] status_r;
  logic                    new_key_r;
  logic [lphm_pkg::DATA_W-1:0] value_out_r;
  logic [LW-1:0]           value_len_r;

  logic out_free;
  logic hit;
  logic empty_slot;

  assign out_free           = ~out_valid_r | ~out_stall;
  assign hit                = (rd_key_r == op_r.key);
  assign empty_slot         = (rd_key_r == '0);
  assign back_stat.clearing = (state_r == lphm_pkg::B_CLEAR);

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r & out_stall;
    q_pop         = 1'b0;
    rd_addr       = idx_r + 1'b1;
    mem_we        = 1'b0;
    mem_wa        = idx_r;
    mem_wkey      = op_r.key;
    mem_wval      = op_r.value[VW-1:0];
    mem_wlen      = op_r.len;
    res_load      = 1'b0;
    res_status    = lphm_pkg::ST_OK;
    res_new       = 1'b0;
    res_val       = '0;
    res_len       = '0;

    case (state_r)
      lphm_pkg::B_CLEAR: begin
        mem_we   = 1'b1;
        mem_wa   = clr_r;
        mem_wkey = '0;
        mem_wval = '0;
        mem_wlen = '0;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == IDX_W'(TABLE_SLOTS - 1)) begin
          state_nxt = lphm_pkg::B_IDLE;
        end
      end

      lphm_pkg::B_IDLE: begin
        rd_addr = q_head.key[IDX_W-1:0];
        if (!q_stat.empty && out_free) begin
          q_pop = 1'b1;
          if (q_head.op == lphm_pkg::OP_BADKEY) begin
            res_load      = 1'b1;
            res_status    = lphm_pkg::ST_BAD_KEY;
            out_valid_nxt = 1'b1;
          end else begin
            idx_nxt   = q_head.key[IDX_W-1:0];
            n_nxt     = '0;
            state_nxt = lphm_pkg::B_PROBE;
          end
        end
      end

      lphm_pkg::B_PROBE: begin
        if (hit || empty_slot || n_r == IDX_W'(TABLE_SLOTS - 1)) begin
          res_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = lphm_pkg::B_IDLE;
          case (op_r.op)
            lphm_pkg::OP_SET: begin
              if (hit) begin
                mem_we = 1'b1;
              end else if (empty_slot && count_r < {1'b0, load_limit}) begin
                mem_we    = 1'b1;
                count_nxt = count_r + 1'b1;
                res_new   = 1'b1;
              end else begin
                res_status = lphm_pkg::ST_FULL;
              end
            end
            lphm_pkg::OP_REMOVE: begin
              if (hit) begin
                // no tombstone: the slot simply becomes empty
                mem_we   = 1'b1;
                mem_wkey = '0;
                mem_wval = '0;
                mem_wlen = '0;
                if (count_r != '0) begin
                  count_nxt = count_r - 1'b1;
                end
              end else begin
                res_status = lphm_pkg::ST_NOT_FOUND;
              end
            end
            default: begin
              // zero-length value reads back as absent
              if (hit && rd_len_r != '0) begin
                res_val = lphm_pkg::DATA_W'(rd_val_r);
                res_len = rd_len_r;
              end else begin
                res_status = lphm_pkg::ST_NOT_FOUND;
              end
            end
          endcase
        end else begin
          idx_nxt = idx_r + 1'b1;
          n_nxt   = n_r + 1'b1;
        end
      end

      default: begin
        state_nxt = lphm_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lphm_pkg::B_CLEAR;
      clr_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    n_r   <= n_nxt;
    if (q_pop) begin
      op_r <= q_head;
    end
    if (res_load) begin
      status_r    <= res_status;
      new_key_r   <= res_new;
      value_out_r <= res_val;
      value_len_r <= res_len;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[mem_wa] <= mem_wkey;
      val_mem[mem_wa] <= mem_wval;
      len_mem[mem_wa] <= mem_wlen;
    end
    rd_key_r <= key_mem[rd_addr];
    rd_val_r <= val_mem[rd_addr];
    rd_len_r <= len_mem[rd_addr];
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_new_key       = new_key_r;
  assign out_value_out     = value_out_r;
  assign out_value_out_len = value_len_r;
  // count only moves when a response is loaded, so it matches the held beat
  assign out_entry_count   = count_r;

endmodule

// File: sv/linear_probe_hash_map.sv
// ----------------------------------------------------------------------
// linear_probe_hash_map : open-addressed hash table with linear probing
// After reset the block sweeps the slot table to empty, one slot per
// cycle, and holds in_stall high meanwhile. A request then leaves the
// request queue and issues the first table read in B_IDLE, and B_PROBE
// walks the probe chain slot by slot, visiting between 1 and
// TABLE_SLOTS slots; the single read port of the slot table sets that
// pace. A zero key is answered from B_IDLE without a probe. Up to two
// requests wait in the queue, so the input keeps taking beats while a
// response is held on a stalled output.
// ----------------------------------------------------------------------
module linear_probe_hash_map #(
  parameter int unsigned TABLE_SLOTS = lphm_pkg::TABLE_SLOTS_DEF,
  parameter int unsigned VALUE_BYTES = lphm_pkg::VALUE_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [lphm_pkg::LIMIT_W-1:0]    cfg_wr_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [lphm_pkg::FUNC_W-1:0]     in_func,
  input  logic [lphm_pkg::KEY_W-1:0]      in_key_hash,
  input  logic [lphm_pkg::DATA_W-1:0]     in_value_data,
  input  logic [lphm_pkg::LEN_W-1:0]      in_value_len,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [lphm_pkg::STAT_W-1:0]     out_status,
  output logic                            out_new_key,
  output logic [lphm_pkg::DATA_W-1:0]     out_value_out,
  output logic [lphm_pkg::LEN_W-1:0]      out_value_out_len,
  output logic [lphm_pkg::COUNT_W-1:0]    out_entry_count
);

  logic [lphm_pkg::LIMIT_W-1:0] load_limit_r;
  lphm_pkg::q_stat_t            q_stat;
  lphm_pkg::back_stat_t         back_stat;
  lphm_pkg::req_t               q_entry;
  lphm_pkg::req_t               q_head;
  logic                         q_push;
  logic                         q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_limit_r <= lphm_pkg::LOAD_LIMIT_RST;
    end else if (cfg_wr_en) begin
      load_limit_r <= cfg_wr_data;
    end
  end

  lphm_front #(
    .VALUE_BYTES (VALUE_BYTES)
  ) u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_key_hash   (in_key_hash),
    .in_value_data (in_value_data),
    .in_value_len  (in_value_len),
    .q_stat        (q_stat),
    .back_stat     (back_stat),
    .q_push        (q_push),
    .q_entry       (q_entry)
  );

  lphm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .q_stat     (q_stat)
  );

  lphm_back #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .VALUE_BYTES (VALUE_BYTES)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .load_limit        (load_limit_r),
    .q_head            (q_head),
    .q_stat            (q_stat),
    .q_pop             (q_pop),
    .back_stat         (back_stat),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_new_key       (out_new_key),
    .out_value_out     (out_value_out),
    .out_value_out_len (out_value_out_len),
    .out_entry_count   (out_entry_count)
  );

`ifndef SYNTHESIS
  // no request may slip in while the table sweep is running
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    back_stat.clearing |-> in_stall)
    else $error("request accepted during table clear");

  a_new_key_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_new_key) |-> (out_status == lphm_pkg::ST_OK))
    else $error("new key flagged on a failed request");

  a_value_len_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_value_out_len != '0) |->
      (out_status == lphm_pkg::ST_OK &&
       out_value_out_len <= lphm_pkg::LEN_W'(VALUE_BYTES)))
    else $error("returned value length out of range");

  // occupancy is bounded by the 8-bit load limit
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !out_entry_count[lphm_pkg::COUNT_W-1])
    else $error("entry count above load limit range");
`endif

endmodule
